// ----- rtl/nfsa_pkg.sv -----
package nfsa_pkg;

	localparam int SLOTS      = 4096;
	localparam int SLOT_BYTES = 64;
	localparam int WORD_BITS  = 32;
	localparam int ROWS       = SLOTS / WORD_BITS;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int OFF_W      = $clog2(WORD_BITS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int BYTE_SH    = $clog2(SLOT_BYTES);
	localparam int ADDR_W     = 48;
	localparam int SIZE_W     = 10;
	localparam int STATUS_W   = 3;

	localparam logic [ADDR_W-1:0] POOL_BASE_RST = 48'h10_0000;
	localparam logic [SIZE_W-1:0] MAX_SIZE      = SIZE_W'(SLOT_BYTES);
	localparam logic [ROW_W:0]    SCAN_LAST     = (ROW_W + 1)'(ROWS);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDRESS = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd4;

	typedef struct packed {
		logic              kind;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   block_address;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic                 rd_en;
		logic [ROW_W-1:0]     rd_row;
		logic                 wr_en;
		logic [ROW_W-1:0]     wr_row;
		logic [WORD_BITS-1:0] wr_data;
	} map_req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_FIN
	} state_t;

endpackage

// ----- rtl/nfsa_map.sv -----
module nfsa_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nfsa_pkg::map_req_t            map_req,
	output logic [nfsa_pkg::WORD_BITS-1:0] rd_word
);
	import nfsa_pkg::*;

	logic [WORD_BITS-1:0] mem [ROWS];
	logic [WORD_BITS-1:0] rd_data_s1;
	logic [ROWS-1:0]      row_vld_q;
	logic                 rd_vld_s1;

	// free-map words; a row never written reads as all free
	always_ff @(posedge clk) begin
		if (map_req.wr_en) begin
			mem[map_req.wr_row] <= map_req.wr_data;
		end
		if (map_req.rd_en) begin
			rd_data_s1 <= mem[map_req.rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (map_req.wr_en) begin
				row_vld_q[map_req.wr_row] <= 1'b1;
			end
			if (map_req.rd_en) begin
				rd_vld_s1 <= row_vld_q[map_req.rd_row];
			end
		end
	end

	assign rd_word = rd_vld_s1 ? rd_data_s1 : '1;

endmodule

// ----- rtl/nfsa_seq.sv -----
module nfsa_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [nfsa_pkg::ADDR_W-1:0] pool_base,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  nfsa_pkg::req_t              in_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output nfsa_pkg::rsp_t              res_data,
	output nfsa_pkg::map_req_t          map_req,
	input  logic [nfsa_pkg::WORD_BITS-1:0] rd_word
);
	import nfsa_pkg::*;

	state_t               state_q, state_d;
	logic [SLOT_W-1:0]    cur_q;
	logic [ROW_W-1:0]     scan_row_q;
	logic [ROW_W:0]       step_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 res_alloc_q;

	logic                 accept;
	logic [ROW_W-1:0]     cur_row;
	logic [OFF_W-1:0]     cur_off;
	logic [ADDR_W-1:0]    offset;
	logic                 free_zero;
	logic                 free_bad;
	logic [SLOT_W-1:0]    free_slot;
	logic                 too_large;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] hits;
	logic [WORD_BITS-1:0] lowest;
	logic [OFF_W-1:0]     enc;
	logic                 hit;
	logic                 slot_is_free;
	logic [ADDR_W-1:0]    slot_addr;

	assign accept  = in_valid && in_ready;
	assign cur_row = cur_q[SLOT_W-1:OFF_W];
	assign cur_off = cur_q[OFF_W-1:0];

	// free decode: offset from pool base, must be slot aligned and inside the pool
	assign offset    = in_data.free_address - pool_base;
	assign free_zero = (in_data.free_address == '0);
	assign free_bad  = (offset[BYTE_SH-1:0] != '0) ||
		(offset[ADDR_W-1:BYTE_SH+SLOT_W] != '0);
	assign free_slot = offset[BYTE_SH+SLOT_W-1:BYTE_SH];
	assign too_large = (in_data.request_size > MAX_SIZE);

	// first row of a scan only looks at or above the cursor
	assign mask   = (step_q == '0) ? ({WORD_BITS{1'b1}} << cur_off) : '1;
	assign hits   = rd_word & mask;
	assign lowest = hits & (~hits + WORD_BITS'(1));
	assign hit    = (hits != '0);

	always_comb begin
		enc = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i]) begin
				enc = enc | OFF_W'(i);
			end
		end
	end

	assign slot_is_free = rd_word[slot_q[OFF_W-1:0]];
	assign slot_addr    = ADDR_W'(slot_q) << BYTE_SH;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_data.kind == KIND_ALLOC) begin
						state_d = too_large ? S_FIN : S_SCAN;
					end else begin
						state_d = (free_zero || free_bad) ? S_FIN : S_FREE_CHK;
					end
				end
			end
			S_SCAN: begin
				if (hit || step_q == SCAN_LAST) begin
					state_d = S_FIN;
				end
			end
			S_FREE_CHK: state_d = S_FIN;
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready               = 1'b0;
		res_valid              = 1'b0;
		res_data.status        = res_status_q;
		res_data.block_address = res_alloc_q ? (pool_base + slot_addr) : '0;
		map_req                = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					map_req.rd_en  = (in_data.kind == KIND_ALLOC) ? !too_large
						: !(free_zero || free_bad);
					map_req.rd_row = (in_data.kind == KIND_ALLOC) ? cur_row
						: free_slot[SLOT_W-1:OFF_W];
				end
			end
			S_SCAN: begin
				if (hit) begin
					map_req.wr_en   = 1'b1;
					map_req.wr_row  = scan_row_q;
					map_req.wr_data = rd_word & ~lowest;
				end else if (step_q != SCAN_LAST) begin
					map_req.rd_en  = 1'b1;
					map_req.rd_row = scan_row_q + ROW_W'(1);
				end
			end
			S_FREE_CHK: begin
				if (!slot_is_free) begin
					map_req.wr_en   = 1'b1;
					map_req.wr_row  = slot_q[SLOT_W-1:OFF_W];
					map_req.wr_data = rd_word | (WORD_BITS'(1) << slot_q[OFF_W-1:0]);
				end
			end
			S_FIN: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN && hit) begin
				cur_q <= {scan_row_q, enc} + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					scan_row_q  <= cur_row;
					step_q      <= '0;
					slot_q      <= free_slot;
					res_alloc_q <= 1'b0;
					if (in_data.kind == KIND_ALLOC) begin
						res_status_q <= too_large ? ST_TOO_LARGE : ST_OK;
					end else begin
						res_status_q <= (!free_zero && free_bad) ? ST_BAD_ADDRESS : ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					slot_q       <= {scan_row_q, enc};
					res_alloc_q  <= 1'b1;
					res_status_q <= ST_OK;
				end else if (step_q == SCAN_LAST) begin
					res_status_q <= ST_POOL_FULL;
				end else begin
					scan_row_q <= scan_row_q + ROW_W'(1);
					step_q     <= step_q + (ROW_W + 1)'(1);
				end
			end
			S_FREE_CHK: begin
				res_status_q <= slot_is_free ? ST_DOUBLE_FREE : ST_OK;
			end
			default: ;
		endcase
	end

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(map_req.rd_en && map_req.wr_en))
		else $error("free map read and write in the same cycle");

	a_alloc_clears_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && map_req.wr_en) |->
		($countones(map_req.wr_data ^ rd_word) == 1))
		else $error("allocation must claim exactly one slot");

	a_free_sets_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE_CHK && map_req.wr_en) |->
		($countones(map_req.wr_data ^ rd_word) == 1))
		else $error("free must release exactly one slot");

	a_cursor_moves_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cur_q) |-> $past(state_q == S_SCAN && hit))
		else $error("cursor moved without an allocation");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("new request taken before result was produced");

endmodule

// ----- rtl/next_fit_slot_allocator_top.sv -----
// Next-fit fixed-slot allocator: 4096 slots of 64 bytes starting at pool_base.
// Request channel (in_valid/in_ready/in_data): kind 0 allocates a slot of up
//   to 64 bytes, kind 1 frees the slot at free_address (zero is a no-op).
// Result channel (out_valid/out_ready/out_data): one result per request with
//   the block address (zero unless an allocation succeeded) and a status.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes pool_base; always
//   ready, write it only while no request is in flight.
// Flow: only one request is in work at a time. Free, oversized and zero
//   requests go to the registered result directly or, for a valid free,
//   through the free check. An allocation reads one 32-slot word of the
//   free map per cycle from the cursor on until it finds a free slot; a
//   full pool costs 129 word reads and leaves the cursor where it was.
// The result sits in an output register, so a new request is accepted while
//   the last result still waits; a stalled receiver holds that result and
//   the next finished result waits inside until the register drains.
// Reset: all slots free (per-word valid bits, no clearing pass), cursor at
//   slot zero, pool_base 0x100000.
module next_fit_slot_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  nfsa_pkg::req_t              in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output nfsa_pkg::rsp_t              out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [nfsa_pkg::ADDR_W-1:0] cfg_data
);
	import nfsa_pkg::*;

	logic [ADDR_W-1:0]    pool_base_q;
	logic                 out_vld_q;
	rsp_t                 out_data_q;

	logic                 res_valid;
	logic                 res_ready;
	rsp_t                 res_data;
	map_req_t             map_req;
	logic [WORD_BITS-1:0] rd_word;

	// config register, single entry
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= POOL_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			pool_base_q <= cfg_data;
		end
	end

	// sequencer: decode, scan, read-modify-write of the free map
	nfsa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.pool_base (pool_base_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.map_req   (map_req),
		.rd_word   (rd_word)
	);

	// free map: one bit per slot, 32 slots per word
	nfsa_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.map_req (map_req),
		.rd_word (rd_word)
	);

	// output register; refills in the cycle it drains
	assign res_ready = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |=> (out_vld_q && $stable(out_data_q)))
		else $error("stalled result changed");

	a_ok_alloc_nonzero_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.status != ST_OK) |-> (res_data.block_address == '0))
		else $error("failed request carries an address");

	a_cfg_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && !in_ready) |-> 1'b0)
		else $error("pool base written while a request is in work");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import nfsa_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_STALL  = 300;

	// Directed script row: a request plus, where it is obvious, the result typed in.
	typedef struct {
		req_t req;
		bit   typed;
		rsp_t want;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	req_t                in_data;
	logic                out_valid;
	logic                out_ready;
	rsp_t                out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [ADDR_W-1:0]   cfg_data;

	// Predictor state: free map, next-fit cursor and our copy of pool_base.
	bit                  slot_is_free [SLOTS];
	logic [SLOT_W-1:0]   cursor;
	logic [ADDR_W-1:0]   base_copy;

	// Results still owed by the allocator, oldest first.
	rsp_t                owed_results [$];
	// Slots the bench has allocated and not yet freed.
	int                  held_slots [$];

	int                  errors;
	int                  cycles;
	int                  requests_taken;
	int                  base_writes;
	int                  status_seen [5];
	int                  sender_gap_pct;
	int                  recv_gap_pct;
	int                  stall_ask;

	script_row_t         script [22];

	next_fit_slot_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Hard stop so a hung handshake cannot run forever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				owed_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// Next-fit allocation and free decoding; updates the predictor state, returns
	// the expected result and sets slot_hit to the slot taken or released (-1 for none).
	function automatic rsp_t predict_outcome(input req_t r, output int slot_hit);
		rsp_t              o;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] slot_no;
		logic [SLOT_W-1:0] s;
		o        = '0;
		o.status = ST_OK;
		slot_hit = -1;
		if (r.kind == KIND_ALLOC) begin
			if (r.request_size > MAX_SIZE) begin
				o.status = ST_TOO_LARGE;
			end else begin
				// A full sweep with nothing free leaves the cursor where it was.
				o.status = ST_POOL_FULL;
				for (int probe = 0; probe < SLOTS; probe++) begin
					s      = cursor;
					cursor = cursor + 1'b1;
					if (slot_is_free[s]) begin
						slot_is_free[s]  = 1'b0;
						o.block_address  = base_copy + ADDR_W'(s) * ADDR_W'(SLOT_BYTES);
						o.status         = ST_OK;
						slot_hit         = int'(s);
						break;
					end
				end
			end
		end else if (r.free_address != '0) begin
			// Offset wraps mod 2^48, so an address below the base is out of range.
			offset  = r.free_address - base_copy;
			slot_no = offset / ADDR_W'(SLOT_BYTES);
			if ((offset % ADDR_W'(SLOT_BYTES)) != '0 || slot_no >= ADDR_W'(SLOTS)) begin
				o.status = ST_BAD_ADDRESS;
			end else if (slot_is_free[slot_no[SLOT_W-1:0]]) begin
				o.status = ST_DOUBLE_FREE;
			end else begin
				slot_is_free[slot_no[SLOT_W-1:0]] = 1'b1;
				slot_hit = int'(slot_no[SLOT_W-1:0]);
			end
		end
		return o;
	endfunction

	function automatic script_row_t step_row(input logic kind, input int size,
			input logic [ADDR_W-1:0] addr, input bit typed,
			input logic [ADDR_W-1:0] want_addr, input logic [STATUS_W-1:0] want_status);
		script_row_t row;
		row.req.kind               = kind;
		row.req.request_size       = SIZE_W'(size);
		row.req.free_address       = addr;
		row.typed                  = typed;
		row.want.block_address     = want_addr;
		row.want.status            = want_status;
		return row;
	endfunction

	// Mostly well-formed traffic: frees of blocks we hold, sane sizes; the
	// rest is double frees, stray addresses, oversized and zero requests.
	function automatic req_t random_request(input int alloc_pct);
		req_t r;
		int   pick;
		r.kind         = ($urandom_range(99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
		r.request_size = ($urandom_range(9) < 7) ? SIZE_W'($urandom_range(SLOT_BYTES))
		                                        : SIZE_W'($urandom_range(1023));
		r.free_address = ADDR_W'({$urandom, $urandom});
		if (r.kind == KIND_FREE) begin
			pick = $urandom_range(99);
			if (pick < 65 && held_slots.size() != 0)
				r.free_address = base_copy + ADDR_W'(SLOT_BYTES) *
					ADDR_W'(held_slots[$urandom_range(held_slots.size() - 1)]);
			else if (pick < 75)
				r.free_address = base_copy + ADDR_W'(SLOT_BYTES) *
					ADDR_W'($urandom_range(SLOTS - 1));
			else if (pick < 82)
				r.free_address = '0;
			else if (pick < 90)
				r.free_address = base_copy + ADDR_W'(SLOT_BYTES) *
					ADDR_W'($urandom_range(SLOTS - 1)) + ADDR_W'($urandom_range(1, SLOT_BYTES - 1));
			else if (pick < 95)
				r.free_address = base_copy + ADDR_W'(SLOT_BYTES) *
					(ADDR_W'(SLOTS) + ADDR_W'($urandom));
		end
		return r;
	endfunction

	// Offer one request, with random gaps first; predict it when it is taken.
	task automatic send_request(input req_t r, input bit typed, input rsp_t want);
		rsp_t predicted;
		int   slot_hit;
		@(negedge clk);
		while ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		predicted = predict_outcome(r, slot_hit);
		owed_results.push_back(typed ? want : predicted);
		requests_taken++;
		if (slot_hit >= 0) begin
			if (r.kind == KIND_ALLOC) begin
				held_slots.push_back(slot_hit);
			end else begin
				for (int i = 0; i < held_slots.size(); i++)
					if (held_slots[i] == slot_hit) begin
						held_slots.delete(i);
						break;
					end
			end
		end
	endtask

	// Drop valid and let every owed result come back, plus a short settle.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_pool_base(input logic [ADDR_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		base_copy = value;
		base_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random ready, or a long hold-off when the main flow asks.
	initial begin
		int stall_seen;
		int hold_left;
		stall_seen = 0;
		hold_left  = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_ask != stall_seen) begin
				stall_seen = stall_ask;
				hold_left  = LONG_STALL;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	// Result checker: oldest owed result against what came out.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("result addr=%h status=%0d with nothing owed",
					out_data.block_address, out_data.status));
			end else begin
				want = owed_results.pop_front();
				if (want.status <= ST_TOO_LARGE)
					status_seen[want.status]++;
				if (out_data.block_address !== want.block_address)
					report_mismatch($sformatf("block_address %h, expected %h",
						out_data.block_address, want.block_address));
				if (out_data.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						out_data.status, want.status));
			end
		end
	end

	initial begin
		errors         = 0;
		cycles         = 0;
		requests_taken = 0;
		base_writes    = 0;
		stall_ask      = 0;
		status_seen    = '{default: 0};
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		// Reset state: every slot free, cursor at zero, base at its reset value.
		foreach (slot_is_free[i]) slot_is_free[i] = 1'b1;
		cursor    = '0;
		base_copy = POOL_BASE_RST;

		// Fresh pool at the reset base, so most results can be written down.
		script = '{
			step_row(KIND_ALLOC, 0,    48'h0,            1, 48'h10_0000, ST_OK),
			step_row(KIND_ALLOC, 64,   48'hFFFF_FFFF_FFFF, 1, 48'h10_0040, ST_OK),
			step_row(KIND_ALLOC, 65,   48'h0,            1, 48'h0,       ST_TOO_LARGE),
			step_row(KIND_ALLOC, 1023, 48'h0,            1, 48'h0,       ST_TOO_LARGE),
			step_row(KIND_FREE,  1023, 48'h0,            1, 48'h0,       ST_OK),
			step_row(KIND_FREE,  0,    48'h10_0000,      1, 48'h0,       ST_OK),
			step_row(KIND_FREE,  0,    48'h10_0000,      1, 48'h0,       ST_DOUBLE_FREE),
			step_row(KIND_FREE,  0,    48'h10_0001,      1, 48'h0,       ST_BAD_ADDRESS),
			// one slot past the end of the pool
			step_row(KIND_FREE,  0,    48'h14_0000,      1, 48'h0,       ST_BAD_ADDRESS),
			// last slot, never handed out
			step_row(KIND_FREE,  0,    48'h13_FFC0,      1, 48'h0,       ST_DOUBLE_FREE),
			step_row(KIND_FREE,  0,    48'hFFFF_FFFF_FFFF, 1, 48'h0,     ST_BAD_ADDRESS),
			// just below the base: offset wraps to a huge slot number
			step_row(KIND_FREE,  0,    48'h0F_FFC0,      1, 48'h0,       ST_BAD_ADDRESS),
			// cursor is past slot 0, so the freed slot 0 is skipped
			step_row(KIND_ALLOC, 1,    48'h0,            1, 48'h10_0080, ST_OK),
			step_row(KIND_FREE,  0,    48'h10_0040,      1, 48'h0,       ST_OK),
			step_row(KIND_ALLOC, 63,   48'h0,            1, 48'h10_00C0, ST_OK),
			step_row(KIND_ALLOC, 64,   48'h1555_5555_5555, 1, 48'h10_0100, ST_OK),
			step_row(KIND_FREE,  682,  48'h10_0080,      1, 48'h0,       ST_OK),
			step_row(KIND_FREE,  0,    48'h10_00C0,      1, 48'h0,       ST_OK),
			step_row(KIND_FREE,  0,    48'h10_0100,      1, 48'h0,       ST_OK),
			step_row(KIND_ALLOC, 341,  48'hAAAA_AAAA_AAAA, 1, 48'h0,     ST_TOO_LARGE),
			step_row(KIND_ALLOC, 64,   48'h0,            0, 48'h0,       ST_OK),
			step_row(KIND_FREE,  0,    48'h10_0140,      0, 48'h0,       ST_OK)
		};

		// Sender idles now and then, receiver stalls about half the time.
		sender_gap_pct = 29;
		recv_gap_pct   = 53;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_request(script[i].req, script[i].typed, script[i].want);

		// Base at zero: slot 0 now sits at address zero, which a free ignores.
		set_pool_base(48'h0);
		repeat (130) send_request(random_request(55), 0, '0);

		// Swap the idle rates, random base, and one long receiver stall
		// while requests keep coming so the input side backs up.
		sender_gap_pct = 53;
		recv_gap_pct   = 29;
		set_pool_base(ADDR_W'({$urandom, $urandom}));
		repeat (60) send_request(random_request(55), 0, '0);
		stall_ask++;
		repeat (70) send_request(random_request(55), 0, '0);

		// No idling. Top base makes block addresses wrap past 2^48, and an
		// allocation-heavy mix keeps the map filling up.
		sender_gap_pct = 0;
		recv_gap_pct   = 0;
		set_pool_base({ADDR_W{1'b1}});
		repeat (130) send_request(random_request(70), 0, '0);

		wait_drained();
		repeat (20) @(posedge clk);
		if (owed_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

		$display("Covered %0d requests under %0d pool_base writes in %0d cycles",
			requests_taken, base_writes, cycles);
		$display("  ok %0d, pool_full %0d, double_free %0d, bad_address %0d, too_large %0d",
			status_seen[ST_OK], status_seen[ST_POOL_FULL], status_seen[ST_DOUBLE_FREE],
			status_seen[ST_BAD_ADDRESS], status_seen[ST_TOO_LARGE]);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- next_fit_slot_allocator_top.f -----
rtl/nfsa_pkg.sv
rtl/nfsa_map.sv
rtl/nfsa_seq.sv
rtl/next_fit_slot_allocator_top.sv
bench/tb.sv
